// ===== hw/rtl/text_console_cell_writer_assert.svh =====
// Assertion macros for the console checker
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Property holds in the same cycle as its trigger
`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console check failed");

// Property holds in the cycle after its trigger
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console check failed");

`endif

// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0]  RESET_ATTR   = 8'h0F;
    localparam logic [COLOR_W-1:0] RESET_FG     = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/tcw_req_if.sv =====
interface tcw_req_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CHAR_W-1:0]    char_code;
    logic [ROW_OUT_W-1:0] read_row;
    logic [COL_OUT_W-1:0] read_column;

    modport source (output valid, kind, char_code, read_row, read_column, input ready);
    modport sink   (input valid, kind, char_code, read_row, read_column, output ready);

endinterface

// ===== hw/rtl/tcw_rsp_if.sv =====
interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_column_out;

    modport source (output valid, cell_value, cursor_row_out, cursor_column_out, input ready);
    modport sink   (input valid, cell_value, cursor_row_out, cursor_column_out, output ready);

endinterface

// ===== hw/rtl/tcw_cell_store.sv =====
module tcw_cell_store #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]    i_wdata,
    input  logic [ADDR_W-1:0]             i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]    o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/text_console_cell_writer.sv =====
// Channel  | Dir | Fields
// ---------+-----+----------------------------------------------
// i_req    | in  | kind, char_code, read_row, read_column
// o_rsp    | out | cell_value, cursor_row_out, cursor_column_out
// i_cfg_*  | in  | write enable, register index, colour nibble
//
// Put, newline and read go through ST_PUT or ST_READ, then ST_DONE, to the result.
// Scroll copies rows up (one cell-store port pair) and blanks the last row in ST_FILL.
// Clear blanks the screen in ST_FILL; every cell goes through one write port.
// After reset a clearing pass over every cell runs before i_req.ready rises.
// A finished result waits in the output register; the next request is taken meanwhile.
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcw_req_if.sink                         i_req,
    tcw_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ADDR        = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST_ADDR = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_ADDR    = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_ADDR        = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW         = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL         = COL_W'(COLUMNS - 1);

    t_state r_state, n_state;

    logic [COLOR_W-1:0]  r_fg, r_bg;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ADDR_W-1:0]   r_cur_addr, n_cur_addr;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ATTR_W-1:0]   r_attr, n_attr;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_rd_ok, n_rd_ok;

    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cell;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;

    logic                req_fire;
    logic                out_free;
    logic                load_out;
    logic                is_newline;
    logic                wrap;
    logic                row_last;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;

    assign req_fire   = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign is_newline = (r_char == NEWLINE_CHAR);
    assign wrap       = is_newline || (r_col == LAST_COL);
    assign row_last   = (r_row == LAST_ROW);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.kind)
                        KIND_PUT:   n_state = ST_PUT;
                        KIND_CLEAR: n_state = ST_FILL;
                        KIND_READ:  n_state = ST_READ;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                n_state = (wrap && row_last) ? ST_SCROLL_RD : ST_DONE;
            end
            ST_READ:      n_state = ST_DONE;
            ST_SCROLL_RD: n_state = ST_SCROLL_WR;
            ST_SCROLL_WR: begin
                n_state = (r_addr == SCROLL_LAST_ADDR) ? ST_FILL : ST_SCROLL_RD;
            end
            ST_FILL: begin
                if (r_addr == LAST_ADDR) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // datapath control
    always_comb begin
        i_req.ready = 1'b0;
        n_row       = r_row;
        n_col       = r_col;
        n_cur_addr  = r_cur_addr;
        n_addr      = r_addr;
        n_attr      = r_attr;
        n_kind      = r_kind;
        n_char      = r_char;
        n_rd_ok     = r_rd_ok;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = {r_attr, BLANK_CHAR};
        mem_raddr   = r_addr;
        load_out    = 1'b0;
        unique case (r_state)
            ST_INIT, ST_FILL: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (req_fire) begin
                    n_kind  = i_req.kind;
                    n_char  = i_req.char_code;
                    n_attr  = {r_bg, r_fg};
                    n_rd_ok = (32'(i_req.read_row) < ROWS) && (32'(i_req.read_column) < COLUMNS);
                    n_addr  = ADDR_W'(32'(i_req.read_row) * COLUMNS + 32'(i_req.read_column));
                    if (i_req.kind == KIND_CLEAR) begin
                        n_addr     = '0;
                        n_row      = '0;
                        n_col      = '0;
                        n_cur_addr = '0;
                    end
                end
            end
            ST_PUT: begin
                if (!is_newline) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur_addr;
                    mem_wdata = {r_attr, r_char};
                end
                if (!wrap) begin
                    n_col      = r_col + 1'b1;
                    n_cur_addr = r_cur_addr + 1'b1;
                end else if (row_last) begin
                    n_col      = '0;
                    n_cur_addr = LAST_ROW_ADDR;
                    n_addr     = '0;
                end else begin
                    n_row      = r_row + 1'b1;
                    n_col      = '0;
                    n_cur_addr = r_cur_addr - ADDR_W'(r_col) + COLS_ADDR;
                end
            end
            ST_READ: begin
            end
            ST_SCROLL_RD: begin
                mem_raddr = r_addr + COLS_ADDR;
            end
            ST_SCROLL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_addr    = r_addr + 1'b1;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_attr      <= RESET_ATTR;
            r_fg        <= RESET_FG;
            r_bg        <= RESET_BG;
            r_row       <= '0;
            r_col       <= '0;
            r_cur_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_attr     <= n_attr;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cur_addr <= n_cur_addr;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FOREGROUND: r_fg <= i_cfg_data;
                    CFG_BACKGROUND: r_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_rd_ok <= n_rd_ok;
        if (load_out) begin
            r_out_cell <= (r_kind == KIND_READ && r_rd_ok) ? mem_rdata : '0;
            r_out_row  <= ROW_OUT_W'(r_row);
            r_out_col  <= COL_OUT_W'(r_col);
        end
    end

    tcw_cell_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.cell_value        = r_out_cell;
    assign o_rsp.cursor_row_out    = r_out_row;
    assign o_rsp.cursor_column_out = r_out_col;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
`include "text_console_cell_writer_assert.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [tcw_pkg::ROW_OUT_W-1:0]    i_rsp_row,
    input logic [tcw_pkg::COL_OUT_W-1:0]    i_rsp_column
);
    import tcw_pkg::*;

    // a held result stays offered
    `TCW_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // one request at a time: busy in the cycle after a request is taken
    `TCW_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    `TCW_ASSERT_NOW(a_col_range, i_clk, i_rst_n, i_rsp_valid, 32'(i_rsp_column) < COLUMNS)

    `TCW_ASSERT_NOW(a_row_range, i_clk, i_rst_n, i_rsp_valid, 32'(i_rsp_row) < ROWS)

endmodule

bind text_console_cell_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_row    (o_rsp.cursor_row_out),
    .i_rsp_column (o_rsp.cursor_column_out)
);
